>>> hdl/dfs_pkg.sv
// Package for the DFS finish-order block: sizes, command codes, FSM states
// and the command / result word structs. No dependencies.
`timescale 1ns / 1ps

package dfs_pkg;

    // Default graph capacity and the reset value of the vertex count register
    localparam int DFS_MAX_VERTICES = 16;
    localparam int DFS_RESET_COUNT  = 16;

    // Command codes
    localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
    localparam logic [1:0] CMD_RUN      = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_ROOT,
        ST_SCAN,
        ST_POP
    } t_state;

    // Command word as taken from the input channel
    typedef struct packed {
        logic [1:0] command;
        logic [3:0] src_vertex;
        logic [3:0] dst_vertex;
    } t_cmd;

    // Result word, one per finished vertex
    typedef struct packed {
        logic [3:0] vertex;
        logic [5:0] finish_time;
        logic       last;
    } t_res;

endpackage

>>> hdl/dfs_if.sv
// Valid/ready channel interfaces of the DFS finish-order block:
// command input, result output and the count register write port.
`timescale 1ns / 1ps

interface dfs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] src_vertex;
    logic [3:0] dst_vertex;

    modport source (output valid, command, src_vertex, dst_vertex, input ready);
    modport sink   (input valid, command, src_vertex, dst_vertex, output ready);
endinterface

interface dfs_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] vertex;
    logic [5:0] finish_time;
    logic       last;

    modport source (output valid, vertex, finish_time, last, input ready);
    modport sink   (input valid, vertex, finish_time, last, output ready);
endinterface

interface dfs_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hdl/dfs_finish_order.sv
// DFS finish-order block, top level: count register, result output
// register and the search engine. Depends on dfs_pkg, dfs_if, dfs_engine.
`timescale 1ns / 1ps

// Usage:
//   i_cmd  : command words (add edge, run, clear). Add edge reads the row,
//            then writes it back in ST_ADD_WR; an out-of-range edge, clear
//            and unknown codes are done in the cycle they are accepted.
//   i_cfg  : writes vertex_count (capped at MAX_VERTICES); always ready.
//            Write it only while no run is in progress.
//   o_res  : one word per active vertex in finish order during a run, with
//            its finish timestamp; last marks the final vertex.
// A run steps through the root indices in ST_ROOT, once more for each tree
// root after its tree is done, and leaves the sweep past the last index.
// Below a root each ST_SCAN step is a discovery or a finish; a finish below
// the root leads to a pop (ST_POP) that refetches the parent's row. The
// registered read of the adjacency RAM sets the pace of each step. No new
// command is taken until the run has stepped through all roots.
// Reset: graph empty, count 16, output empty. Clearing is instant through
// per-row valid bits.
// Stall: a finish waits while the output register holds an untaken word;
// the search resumes the cycle it is taken.

module dfs_finish_order #(
    parameter int MAX_VERTICES = dfs_pkg::DFS_MAX_VERTICES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dfs_cmd_if.sink  i_cmd,
    dfs_cfg_if.sink  i_cfg,
    dfs_res_if.source o_res
);

    import dfs_pkg::*;

    logic [4:0] r_vcount;
    logic [4:0] w_count;
    t_cmd       w_cmd;
    t_res       w_res;
    t_res       r_out;
    logic       r_out_valid;
    logic       w_res_valid, w_res_ready, w_cmd_ready;

    // count register
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= 5'(DFS_RESET_COUNT);
        end else if (i_cfg.valid) begin
            r_vcount <= i_cfg.data;
        end
    end

    assign w_count = (32'(r_vcount) > MAX_VERTICES) ? 5'(MAX_VERTICES) : r_vcount;

    // command word
    assign w_cmd.command    = i_cmd.command;
    assign w_cmd.src_vertex = i_cmd.src_vertex;
    assign w_cmd.dst_vertex = i_cmd.dst_vertex;
    assign i_cmd.ready      = w_cmd_ready;

    dfs_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (w_cmd_ready),
        .i_cmd       (w_cmd),
        .i_count     (w_count),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // output register
    assign w_res_ready = !r_out_valid || o_res.ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_ready && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.vertex      = r_out.vertex;
    assign o_res.finish_time = r_out.finish_time;
    assign o_res.last        = r_out.last;

    // checks
    a_reset_count: assert property (@(posedge i_clk)
        !i_rst_n |=> r_vcount == 5'(DFS_RESET_COUNT))
        else $error("vertex count not at reset value");

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> w_res_ready)
        else $error("engine produced a word with no room in output register");

    a_no_cmd_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !w_cmd_ready)
        else $error("command accepted while a run emits");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid && w_res.last |=> !w_res_valid)
        else $error("word emitted right after the last one");

endmodule

>>> hdl/dfs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module dfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port, read port with output register (holds when not reading)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/dfs_engine.sv
// Search engine: adjacency RAM with row valid bits, path stack RAM,
// visited flags and the sequencer. Depends on dfs_pkg and dfs_ram.
`timescale 1ns / 1ps

module dfs_engine #(
    parameter int MAX_VERTICES = dfs_pkg::DFS_MAX_VERTICES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  dfs_pkg::t_cmd i_cmd,
    input  logic [4:0]    i_count,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output dfs_pkg::t_res o_res
);

    import dfs_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int DW    = $clog2(MAX_VERTICES + 1);
    localparam int CLK_N = $clog2(2 * MAX_VERTICES + 1);
    localparam int CLK_W = (CLK_N < 6) ? 6 : CLK_N;

    // registers
    t_state                  r_state, n_state;
    logic [MAX_VERTICES-1:0] r_row_valid, n_row_valid;
    logic [MAX_VERTICES-1:0] r_visited, n_visited;
    logic [VW-1:0]           r_top, n_top;
    logic [DW-1:0]           r_depth, n_depth;
    logic [4:0]              r_root, n_root;
    logic [4:0]              r_emit, n_emit;
    logic [CLK_W-1:0]        r_clk, n_clk;
    logic [VW-1:0]           r_src, n_src;
    logic [VW-1:0]           r_dst, n_dst;

    // memory ports
    logic                    adj_we, adj_re;
    logic [VW-1:0]           adj_waddr, adj_raddr;
    logic [MAX_VERTICES-1:0] adj_wdata, adj_q;
    logic                    stk_we, stk_re;
    logic [VW-1:0]           stk_waddr, stk_raddr;
    logic [VW-1:0]           stk_wdata, stk_q;

    // scan datapath
    logic [MAX_VERTICES-1:0] w_row, w_active, w_cand, w_dst_bit;
    logic                    w_found;
    logic [VW-1:0]           w_next;
    logic                    w_accept, w_edge_ok;

    dfs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .o_rdata (adj_q)
    );

    dfs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_q)
    );

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign w_accept    = i_cmd_valid && o_cmd_ready;
    assign w_edge_ok   = ({1'b0, i_cmd.src_vertex} < i_count) &&
                         ({1'b0, i_cmd.dst_vertex} < i_count);

    // row read back: a row never written since the last clear reads as empty
    always_comb begin
        if (r_state == ST_ADD_WR) begin
            w_row = r_row_valid[r_src] ? adj_q : '0;
        end else begin
            w_row = r_row_valid[r_top] ? adj_q : '0;
        end
    end

    // active vertex mask and one-hot of the edge end
    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) begin
            w_active[i]  = (32'(i) < 32'(i_count));
            w_dst_bit[i] = (VW'(i) == r_dst);
        end
    end

    // lowest unvisited active neighbour of the top vertex
    assign w_cand  = w_row & ~r_visited & w_active;
    assign w_found = |w_cand;
    always_comb begin
        w_next = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (w_cand[i]) begin
                w_next = VW'(i);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.command)
                        CMD_ADD_EDGE: n_state = w_edge_ok ? ST_ADD_WR : ST_IDLE;
                        CMD_RUN:      n_state = ST_ROOT;
                        default:      n_state = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_WR: n_state = ST_IDLE;
            ST_ROOT: begin
                if (r_root >= i_count) begin
                    n_state = ST_IDLE;
                end else if (!r_visited[VW'(r_root)]) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!w_found && i_res_ready) begin
                    n_state = (r_depth == DW'(1)) ? ST_ROOT : ST_POP;
                end
            end
            ST_POP:  n_state = ST_SCAN;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_row_valid = r_row_valid;
        n_visited   = r_visited;
        n_top       = r_top;
        n_depth     = r_depth;
        n_root      = r_root;
        n_emit      = r_emit;
        n_clk       = r_clk;
        n_src       = r_src;
        n_dst       = r_dst;
        adj_we      = 1'b0;
        adj_waddr   = r_src;
        adj_wdata   = w_row | w_dst_bit;
        adj_re      = 1'b0;
        adj_raddr   = r_top;
        stk_we      = 1'b0;
        stk_waddr   = VW'(r_depth);
        stk_wdata   = w_next;
        stk_re      = 1'b0;
        stk_raddr   = VW'(r_depth - DW'(2));
        o_res_valid = 1'b0;
        o_res.vertex      = 4'(r_top);
        o_res.finish_time = 6'(r_clk + 1'b1);
        o_res.last        = (r_emit == (i_count - 5'd1));
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_cmd.command)
                        CMD_ADD_EDGE: begin
                            n_src     = VW'(i_cmd.src_vertex);
                            n_dst     = VW'(i_cmd.dst_vertex);
                            adj_re    = w_edge_ok;
                            adj_raddr = VW'(i_cmd.src_vertex);
                        end
                        CMD_RUN: begin
                            n_visited = '0;
                            n_clk     = '0;
                            n_root    = '0;
                            n_emit    = '0;
                            n_depth   = '0;
                        end
                        CMD_CLEAR: n_row_valid = '0;
                        default: ;
                    endcase
                end
            end
            // read-modify-write of the source row
            ST_ADD_WR: begin
                adj_we             = 1'b1;
                n_row_valid[r_src] = 1'b1;
            end
            // next white root: discover it and fetch its row
            ST_ROOT: begin
                if (r_root < i_count) begin
                    if (r_visited[VW'(r_root)]) begin
                        n_root = r_root + 5'd1;
                    end else begin
                        n_visited[VW'(r_root)] = 1'b1;
                        n_clk     = r_clk + 1'b1;
                        stk_we    = 1'b1;
                        stk_waddr = '0;
                        stk_wdata = VW'(r_root);
                        n_top     = VW'(r_root);
                        n_depth   = DW'(1);
                        adj_re    = 1'b1;
                        adj_raddr = VW'(r_root);
                    end
                end
            end
            // push a white neighbour, or finish the top vertex
            ST_SCAN: begin
                if (w_found) begin
                    n_visited[w_next] = 1'b1;
                    n_clk     = r_clk + 1'b1;
                    stk_we    = 1'b1;
                    n_depth   = r_depth + DW'(1);
                    n_top     = w_next;
                    adj_re    = 1'b1;
                    adj_raddr = w_next;
                end else if (i_res_ready) begin
                    o_res_valid = 1'b1;
                    n_clk       = r_clk + 1'b1;
                    n_emit      = r_emit + 5'd1;
                    n_depth     = r_depth - DW'(1);
                    stk_re      = (r_depth != DW'(1));
                end
            end
            // parent back from the stack: refetch its row
            ST_POP: begin
                n_top     = stk_q;
                adj_re    = 1'b1;
                adj_raddr = stk_q;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_row_valid <= '0;
            r_visited   <= '0;
            r_depth     <= '0;
            r_root      <= '0;
            r_emit      <= '0;
            r_clk       <= '0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_visited   <= n_visited;
            r_depth     <= n_depth;
            r_root      <= n_root;
            r_emit      <= n_emit;
            r_clk       <= n_clk;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_src <= n_src;
        r_dst <= n_dst;
    end

endmodule
